/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* design/tvb_pkg.sv */
// ----------------------------------------------------------------------------
// tvb_pkg
// Types and constants of the tagged value box / unbox / hash unit
// ----------------------------------------------------------------------------
package tvb_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_BOX_REAL = 2'd0,
    REQ_BOX_INT  = 2'd1,
    REQ_BOX_BOOL = 2'd2,
    REQ_UNBOX    = 2'd3
  } req_e;

  // decoded value types
  typedef enum logic [2:0] {
    TYPE_NIL  = 3'd0,
    TYPE_REAL = 3'd1,
    TYPE_INT  = 3'd2,
    TYPE_BOOL = 3'd3,
    TYPE_HEAP = 3'd4
  } type_code_e;

  // how the back end forms the hash
  typedef enum logic [1:0] {
    HASH_ZERO = 2'd0,
    HASH_COPY = 2'd1,
    HASH_MIX  = 2'd2
  } hash_sel_e;

  // tag values in the low bits of a boxed word
  localparam logic [0:0] TagReal = 1'b1;
  localparam logic [1:0] TagInt  = 2'b10;
  localparam logic [2:0] TagBool = 3'b100;

  // murmur3 fmix64 multipliers
  localparam logic [63:0] FmixC1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FmixC2 = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned FmixShift = 33;

  // default depth of the front-to-back queue
  localparam int unsigned QueueDepthDefault = 4;

  // one classified transaction in flight between front and back
  typedef struct packed {
    logic       ok;
    logic [63:0] boxed_word;
    type_code_e type_code;
    logic [63:0] unboxed_bits;
    hash_sel_e  hash_sel;
    logic       hash_valid;
  } entry_t;

  // queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* design/tvb_if.sv */
// ----------------------------------------------------------------------------
// tvb_if
// Request and response channel interfaces (valid / ready)
// ----------------------------------------------------------------------------
interface tvb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface tvb_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [63:0] boxed_word;
  logic [2:0]  type_code;
  logic [63:0] unboxed_bits;
  logic [63:0] hash_value;
  logic        hash_valid;

  modport source (output valid, output ok, output boxed_word, output type_code,
                  output unboxed_bits, output hash_value, output hash_valid,
                  input ready);
  modport sink   (input valid, input ok, input boxed_word, input type_code,
                  input unboxed_bits, input hash_value, input hash_valid,
                  output ready);
endinterface

/* design/tvb_front.sv */
// ----------------------------------------------------------------------------
// tvb_front
// Accepts requests, boxes values and decodes tags into queue entries
// ----------------------------------------------------------------------------
module tvb_front
  import tvb_pkg::*;
(
  tvb_req_if.sink req_i,
  input  logic    push_ready_i,
  output logic    push_valid_o,
  output entry_t  push_entry_o
);

  logic [63:0] v;
  entry_t      e;

  assign v = req_i.value;

  // handshake straight through to the queue
  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

  // classify and box / decode
  always_comb begin
    e            = '0;
    e.ok         = 1'b1;
    e.type_code  = TYPE_NIL;
    e.hash_sel   = HASH_ZERO;
    e.hash_valid = 1'b0;
    unique case (req_e'(req_i.req_type))
      REQ_BOX_REAL: begin
        // inline only when exponent bits 62 and 61 differ
        if (v[62] != v[61]) begin
          e.boxed_word = {v[63], v[61:0], TagReal};
        end else begin
          e.ok = 1'b0;
        end
      end
      REQ_BOX_INT: begin
        // fits int62 when the top three bits agree
        if ((v[63] == v[62]) && (v[62] == v[61])) begin
          e.boxed_word = {v[61:0], TagInt};
        end else begin
          e.ok = 1'b0;
        end
      end
      REQ_BOX_BOOL: begin
        e.boxed_word = {60'd0, v[0], TagBool};
      end
      REQ_UNBOX: begin
        e.hash_valid = 1'b1;
        priority if (v[0]) begin
          e.type_code    = TYPE_REAL;
          e.unboxed_bits = {v[63], ~v[62], v[62:1]};
          e.hash_sel     = HASH_MIX;
        end else if (v[1]) begin
          // tag 2 and tag 6 both decode as int
          e.type_code    = TYPE_INT;
          e.unboxed_bits = {{2{v[63]}}, v[63:2]};
          e.hash_sel     = HASH_MIX;
        end else if (v[2]) begin
          e.type_code    = TYPE_BOOL;
          e.unboxed_bits = {63'd0, |v[63:3]};
          e.hash_sel     = HASH_COPY;
        end else if (v == 64'd0) begin
          e.type_code = TYPE_NIL;
        end else begin
          // heap reference: pointer passes through, no hash
          e.type_code    = TYPE_HEAP;
          e.unboxed_bits = v;
          e.hash_valid   = 1'b0;
        end
      end
    endcase
  end

  assign push_entry_o = e;

endmodule

/* design/tvb_queue.sv */
// ----------------------------------------------------------------------------
// tvb_queue
// Short FIFO between the classifying front and the hashing back end
// ----------------------------------------------------------------------------
module tvb_queue
  import tvb_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  entry_t      push_entry_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output entry_t      pop_entry_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              full, empty, push, pop;

  assign full  = (cnt_q == CntW'(Depth));
  assign empty = (cnt_q == '0);
  assign push  = push_valid_i && !full;
  assign pop   = pop_ready_i && !empty;

  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign stat_o       = '{full: full, empty: empty};

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* design/tvb_back.sv */
// ----------------------------------------------------------------------------
// tvb_back
// Four-stage fmix64 pipeline with the response output register
// ----------------------------------------------------------------------------
module tvb_back
  import tvb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  entry_t   in_entry_i,
  tvb_rsp_if.source rsp_o
);

  // stage valids and backpressure chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || rsp_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  entry_t      e1_q, e2_q, e3_q;
  logic [63:0] p0a_q, p0b_q;
  logic [31:0] p1a_q, p2a_q, p1b_q, p2b_q;
  logic [63:0] h2_q;

  logic [63:0] x1, sum2, sum4, h4, hash4;

  // stage 1: first xorshift, partial products with the first multiplier
  assign x1 = in_entry_i.unboxed_bits ^ (in_entry_i.unboxed_bits >> FmixShift);

  // stage 2: fold partial products, second xorshift
  assign sum2 = p0a_q + {p1a_q + p2a_q, 32'd0};

  // stage 4: fold partial products, last xorshift, hash select
  assign sum4 = p0b_q + {p1b_q + p2b_q, 32'd0};
  assign h4   = sum4 ^ (sum4 >> FmixShift);

  always_comb begin
    unique case (e3_q.hash_sel)
      HASH_MIX:  hash4 = h4;
      HASH_COPY: hash4 = e3_q.unboxed_bits;
      default:   hash4 = '0;
    endcase
  end

  // valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      e1_q  <= in_entry_i;
      p0a_q <= x1[31:0] * FmixC1[31:0];
      p1a_q <= 32'(x1[31:0] * FmixC1[63:32]);
      p2a_q <= 32'(x1[63:32] * FmixC1[31:0]);
    end
    if (rdy2 && v1_q) begin
      e2_q <= e1_q;
      h2_q <= sum2 ^ (sum2 >> FmixShift);
    end
    if (rdy3 && v2_q) begin
      e3_q  <= e2_q;
      p0b_q <= h2_q[31:0] * FmixC2[31:0];
      p1b_q <= 32'(h2_q[31:0] * FmixC2[63:32]);
      p2b_q <= 32'(h2_q[63:32] * FmixC2[31:0]);
    end
    if (rdy4 && v3_q) begin
      rsp_o.ok           <= e3_q.ok;
      rsp_o.boxed_word   <= e3_q.boxed_word;
      rsp_o.type_code    <= e3_q.type_code;
      rsp_o.unboxed_bits <= e3_q.unboxed_bits;
      rsp_o.hash_value   <= hash4;
      rsp_o.hash_valid   <= e3_q.hash_valid;
    end
  end

  assign rsp_o.valid = v4_q;

endmodule

/* design/tagged_value_box_unbox_hash.sv */
// ----------------------------------------------------------------------------
// tagged_value_box_unbox_hash
// Boxes reals, ints and bools into tagged words; unboxes and hashes them
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the queue is not full, and returns
// exactly one response per request, in order. A request is classified and
// boxed or decoded in the front end in the cycle it is accepted and written
// into a short queue; the back end then runs the Murmur3 fmix64 hash through
// four pipeline stages, the last of which is the response register. A request
// is held in a queue entry, then in the three hash stage registers and then in
// the response register; the hash stages are set by the two 64-bit multiplies
// of fmix64, each split into 32-bit partial products registered before they
// are summed. Requests are refused only when the queue (QueueDepth entries) is
// full while the response side stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tagged_value_box_unbox_hash
  import tvb_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tvb_req_if.sink   req_i,
  tvb_rsp_if.source rsp_o
);

  logic        push_valid, push_ready;
  entry_t      push_entry;
  logic        pop_valid, pop_ready;
  entry_t      pop_entry;
  queue_stat_t q_stat;

  // front end: classify and box
  tvb_front u_front (
    .req_i        (req_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry)
  );

  // decoupling queue
  tvb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry),
    .stat_o       (q_stat)
  );

  // back end: hash pipeline and response register
  tvb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pop_valid),
    .in_ready_o (pop_ready),
    .in_entry_i (pop_entry),
    .rsp_o      (rsp_o)
  );

  // checks
  `ASSERT_PROP(a_heap_no_hash, clk_i, rst_ni, rsp_o.valid && rsp_o.type_code == TYPE_HEAP |-> !rsp_o.hash_valid, "heap response carries a hash")
  `ASSERT_PROP(a_fail_zero, clk_i, rst_ni, rsp_o.valid && !rsp_o.ok |-> rsp_o.boxed_word == 64'd0 && !rsp_o.hash_valid, "failed box carries data")
  `ASSERT_PROP(a_accept_queued, clk_i, rst_ni, req_i.valid && req_i.ready |=> !q_stat.empty, "accepted transaction not queued")
  `ASSERT_NEVER(a_queue_stat, clk_i, rst_ni, q_stat.full && q_stat.empty, "queue full and empty at once")

endmodule
